FILE: rtl/tpsv_pkg.sv
// shared types and constants of the trapezoid pulse source
// no dependencies
package tpsv_pkg;

  localparam logic [31:0] MIN_EDGE_TICKS = 32'd1;

  localparam logic [2:0] SEG_IDLE = 3'd0;
  localparam logic [2:0] SEG_RISE = 3'd1;
  localparam logic [2:0] SEG_HIGH = 3'd2;
  localparam logic [2:0] SEG_FALL = 3'd3;
  localparam logic [2:0] SEG_LOW  = 3'd4;

  localparam logic [2:0] REG_LOW_LEVEL    = 3'd0;
  localparam logic [2:0] REG_HIGH_LEVEL   = 3'd1;
  localparam logic [2:0] REG_START_DELAY  = 3'd2;
  localparam logic [2:0] REG_RISE_TICKS   = 3'd3;
  localparam logic [2:0] REG_FALL_TICKS   = 3'd4;
  localparam logic [2:0] REG_ON_TICKS     = 3'd5;
  localparam logic [2:0] REG_PERIOD_TICKS = 3'd6;
  localparam logic [2:0] REG_CYCLE_COUNT  = 3'd7;

  // sideband carried through the quotient pipeline
  typedef struct packed {
    logic [2:0]         seg;
    logic signed [15:0] base;
    logic               neg;
  } div_side_t;

endpackage

FILE: rtl/tpsv_mod_pipe.sv
// pipelined restoring remainder unit, one quotient bit per stage
// depends on tpsv_pkg
module tpsv_mod_pipe
  import tpsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic        in_active,
  output logic        out_valid,
  output logic [31:0] remainder,
  output logic        out_active
);

  logic        v   [0:32];
  logic        act [0:32];
  logic [31:0] rem [0:32];
  logic [31:0] dvd [0:32];
  logic [31:0] dsr [0:32];
  logic [31:0] rem_next [1:32];

  always_comb begin
    logic [32:0] trial;
    trial = '0;
    for (int i = 1; i <= 32; i++) begin
      trial = {rem[i-1], dvd[i-1][31]};
      if (trial >= {1'b0, dsr[i-1]}) begin
        rem_next[i] = 32'(trial - {1'b0, dsr[i-1]});
      end else begin
        rem_next[i] = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= 32; i++) v[i] <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int i = 1; i <= 32; i++) v[i] <= v[i-1];
    end
    rem[0] <= '0;
    dvd[0] <= dividend;
    dsr[0] <= divisor;
    act[0] <= in_active;
    for (int i = 1; i <= 32; i++) begin
      rem[i] <= rem_next[i];
      dvd[i] <= {dvd[i-1][30:0], 1'b0};
      dsr[i] <= dsr[i-1];
      act[i] <= act[i-1];
    end
  end

  assign out_valid  = v[32];
  assign remainder  = rem[32];
  assign out_active = act[32];

endmodule

FILE: rtl/tpsv_div_pipe.sv
// pipelined restoring divider for the edge interpolation, 16 quotient bits
// depends on tpsv_pkg; quotient must be below 2**16
module tpsv_div_pipe
  import tpsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  input  div_side_t   in_side,
  output logic        out_valid,
  output logic [15:0] quotient,
  output div_side_t   out_side
);

  logic        v    [0:16];
  div_side_t   side [0:16];
  logic [31:0] rem  [0:16];
  logic [15:0] dvd  [0:16];
  logic [31:0] dsr  [0:16];
  logic [15:0] q    [0:16];
  logic [31:0] rem_next [1:16];
  logic        bit_next [1:16];

  always_comb begin
    logic [32:0] trial;
    trial = '0;
    for (int i = 1; i <= 16; i++) begin
      trial = {rem[i-1], dvd[i-1][15]};
      bit_next[i] = (trial >= {1'b0, dsr[i-1]});
      if (bit_next[i]) begin
        rem_next[i] = 32'(trial - {1'b0, dsr[i-1]});
      end else begin
        rem_next[i] = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= 16; i++) v[i] <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int i = 1; i <= 16; i++) v[i] <= v[i-1];
    end
    rem[0]  <= dividend[47:16];
    dvd[0]  <= dividend[15:0];
    dsr[0]  <= divisor;
    q[0]    <= '0;
    side[0] <= in_side;
    for (int i = 1; i <= 16; i++) begin
      rem[i]  <= rem_next[i];
      dvd[i]  <= {dvd[i-1][14:0], 1'b0};
      dsr[i]  <= dsr[i-1];
      q[i]    <= {q[i-1][14:0], bit_next[i]};
      side[i] <= side[i-1];
    end
  end

  assign out_valid = v[16];
  assign quotient  = q[16];
  assign out_side  = side[16];

endmodule

FILE: rtl/trapezoid_pulse_source_value.sv
// top level of the trapezoid pulse source: registers, pipeline and output
// depends on tpsv_pkg, tpsv_mod_pipe, tpsv_div_pipe
module trapezoid_pulse_source_value
  import tpsv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        time_now,
  output logic               result_valid,
  output logic signed [15:0] level_out,
  output logic [2:0]         segment,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // one request per clock, never stalled; busy is always low. each request
  // gives one result, in order. each request passes through the 32-stage
  // remainder pipeline (elapsed modulo period) and the 16-stage
  // interpolation divider. the receiver cannot hold results off, so nothing
  // is buffered. cfg_ready is always high; registers are read deep in the
  // pipeline, so write them only while no request is in flight

  logic signed [15:0] low_level, high_level;
  logic [31:0] start_delay, rise_ticks, fall_ticks, on_ticks, period_ticks;
  logic [15:0] cycle_count;

  // values derived from the registers, refreshed every cycle
  logic [31:0] per_eff, rise_eff, fall_eff;
  logic [47:0] limit;
  logic [32:0] top;
  logic [33:0] fall_end;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_level    <= '0;
      high_level   <= '0;
      start_delay  <= '0;
      rise_ticks   <= '0;
      fall_ticks   <= '0;
      on_ticks     <= '0;
      period_ticks <= 32'd1;
      cycle_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LEVEL:    low_level    <= cfg_data[15:0];
        REG_HIGH_LEVEL:   high_level   <= cfg_data[15:0];
        REG_START_DELAY:  start_delay  <= cfg_data;
        REG_RISE_TICKS:   rise_ticks   <= cfg_data;
        REG_FALL_TICKS:   fall_ticks   <= cfg_data;
        REG_ON_TICKS:     on_ticks     <= cfg_data;
        REG_PERIOD_TICKS: period_ticks <= cfg_data;
        REG_CYCLE_COUNT:  cycle_count  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero period and zero edges are replaced before use
  always_ff @(posedge clk) begin
    per_eff  <= (period_ticks == '0) ? 32'd1 : period_ticks;
    rise_eff <= (rise_ticks == '0) ? MIN_EDGE_TICKS : rise_ticks;
    fall_eff <= (fall_ticks == '0) ? MIN_EDGE_TICKS : fall_ticks;
    limit    <= 48'(cycle_count) * 48'(per_eff);
    top      <= {1'b0, rise_eff} + {1'b0, on_ticks};
    fall_end <= {1'b0, top} + {2'b0, fall_eff};
  end

  // stage 0: capture time
  logic        v0;
  logic [31:0] t0;
  // stage 1: elapsed time and start test
  logic        v1, ge1;
  logic [31:0] el1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= start && !busy;
      v1 <= v0;
    end
    t0  <= time_now;
    ge1 <= (t0 >= start_delay);
    el1 <= t0 - start_delay;
  end

  // still within the configured number of periods (equality counts)
  logic act1;
  assign act1 = ge1 && ({16'b0, el1} <= limit);

  logic        vm, actm;
  logic [31:0] phase;

  tpsv_mod_pipe u_mod (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v1),
    .dividend   (el1),
    .divisor    (per_eff),
    .in_active  (act1),
    .out_valid  (vm),
    .remainder  (phase),
    .out_active (actm)
  );

  // segment decode and interpolation operands
  logic [2:0]         seg_c;
  logic signed [15:0] from_c, to_c;
  logic [31:0]        num_c, den_c;
  logic signed [16:0] diff_c;
  logic [16:0]        mag_c;

  always_comb begin
    seg_c  = SEG_IDLE;
    from_c = low_level;
    to_c   = low_level;
    num_c  = '0;
    den_c  = 32'd1;
    if (actm) begin
      if ({1'b0, phase} < {1'b0, rise_eff}) begin
        seg_c  = SEG_RISE;
        from_c = low_level;
        to_c   = high_level;
        num_c  = phase;
        den_c  = rise_eff;
      end else if ({1'b0, phase} < top) begin
        seg_c  = SEG_HIGH;
        from_c = high_level;
        to_c   = high_level;
      end else if ({2'b0, phase} < fall_end) begin
        seg_c  = SEG_FALL;
        from_c = high_level;
        to_c   = low_level;
        num_c  = 32'({1'b0, phase} - top);
        den_c  = fall_eff;
      end else begin
        seg_c  = SEG_LOW;
      end
    end
    diff_c = 17'(to_c) - 17'(from_c);
    mag_c  = diff_c[16] ? 17'(-diff_c) : 17'(diff_c);
  end

  // stage: operands registered
  logic        v3;
  div_side_t   side3;
  logic [15:0] mag3;
  logic [31:0] num3, den3;
  // stage: product registered
  logic        v4;
  div_side_t   side4;
  logic [47:0] prod4;
  logic [31:0] den4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= vm;
      v4 <= v3;
    end
    side3.seg  <= seg_c;
    side3.base <= from_c;
    side3.neg  <= diff_c[16];
    mag3       <= mag_c[15:0];
    num3       <= num_c;
    den3       <= den_c;
    side4      <= side3;
    prod4      <= 48'(mag3) * 48'(num3);
    den4       <= den3;
  end

  logic        vd;
  logic [15:0] quo;
  div_side_t   sided;

  tpsv_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .dividend  (prod4),
    .divisor   (den4),
    .in_side   (side4),
    .out_valid (vd),
    .quotient  (quo),
    .out_side  (sided)
  );

  // truncation toward zero: apply the sign to the magnitude quotient
  logic signed [16:0] level_c;
  assign level_c = 17'(sided.base) + (sided.neg ? -17'(quo) : 17'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vd;
    end
    level_out <= level_c[15:0];
    segment   <= sided.seg;
  end

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (segment <= SEG_LOW))
    else $error("segment code out of range");

  a_high_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && segment == SEG_HIGH |-> level_out == high_level)
    else $error("high segment without high level");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && (segment == SEG_IDLE || segment == SEG_LOW) |-> level_out == low_level)
    else $error("resting segment without low level");

endmodule
